@@ rtl/fixed_chunk_pool_allocator_unit_macros.svh @@
// Assertion macros shared by the chunk pool allocator RTL.
// Included by the modules that carry assertions; no other dependencies.
`ifndef FIXED_CHUNK_POOL_ALLOCATOR_UNIT_MACROS_SVH
`define FIXED_CHUNK_POOL_ALLOCATOR_UNIT_MACROS_SVH

// Condition that must hold at every clock edge out of reset
`define FCPA_ASSERT_INV(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("fcpa invariant violated");

// Antecedent in one cycle implies consequent in the next
`define FCPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fcpa next-cycle check failed");

`endif

@@ rtl/fcpa_pkg.sv @@
// Shared types and constants for the chunk pool allocator.
// No dependencies; used by every module of the block but fcpa_stack_mem.
package fcpa_pkg;

	// Field and register widths
	localparam int CFG_W = 11;
	localparam int IDX_W = 10;
	localparam int CMD_W = 2;
	localparam int REG_W = 2;

	// Default pool capacity and reset values of the limit registers
	localparam int MAX_CHUNKS_DEF = 1024;
	localparam int TOTAL_RST      = 1024;
	localparam logic [CFG_W-1:0] DANGER_RST = 11'd972;
	localparam logic [CFG_W-1:0] SAFE_RST   = 11'd921;

	// Register indexes on the config port
	localparam logic [REG_W-1:0] REG_TOTAL  = 2'd0;
	localparam logic [REG_W-1:0] REG_DANGER = 2'd1;
	localparam logic [REG_W-1:0] REG_SAFE   = 2'd2;

	// Commands
	typedef enum logic [CMD_W-1:0] {
		CMD_ALLOC = 2'd0,
		CMD_FREE  = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	// What the decode stage hands to the result stage
	typedef struct packed {
		logic             ok;
		logic             pop;
		logic [IDX_W-1:0] run_idx;
	} s1_info_t;

endpackage

@@ rtl/fixed_chunk_pool_allocator_unit.sv @@
// Chunk pool allocator: hands out chunk indices from a pool of equal chunks.
// Freed chunks go on a LIFO stack kept in a one-port-write, one-port-read
// memory and are reused before the never-used run, which is given out upward.
// Every command (allocate, free, query) returns one result with the free
// count, an over-safeline flag and the danger excess. One command is taken
// per cycle while in_stall is low. The accepting edge decodes, updates the
// counters and starts the stack memory read; a later edge with the result
// register free loads it. A stalled result holds one further command in
// the decode stage. Writing total_chunks restarts the pool at once; no
// clearing pass is needed after reset. Depends on fcpa_pkg, fcpa_ctrl,
// fcpa_status, fcpa_stack_mem.
module fixed_chunk_pool_allocator_unit #(
	parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fcpa_pkg::CMD_W-1:0]    command,
	input  logic [fcpa_pkg::IDX_W-1:0]    chunk_index,
	input  logic                          cfg_we,
	input  logic [fcpa_pkg::REG_W-1:0]    cfg_index,
	input  logic [fcpa_pkg::CFG_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
	output logic [fcpa_pkg::CFG_W-1:0]    free_count,
	output logic [fcpa_pkg::CFG_W-1:0]    danger_excess,
	output logic                          over_safeline
);

	localparam int CW = $clog2(MAX_CHUNKS + 1);
	localparam int AW = $clog2(MAX_CHUNKS);

	logic out_free, valid_s1;
	fcpa_pkg::s1_info_t info_s1;
	logic [CW-1:0] total, free;
	logic [fcpa_pkg::CFG_W-1:0] danger, safe;
	logic mem_we, mem_re;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [fcpa_pkg::IDX_W-1:0] mem_wdata, mem_rdata;

	// Decode, counters and config
	fcpa_ctrl #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.CW(CW),
		.AW(AW)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.chunk_index(chunk_index),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.out_free   (out_free),
		.valid_s1   (valid_s1),
		.info_s1    (info_s1),
		.total      (total),
		.free       (free),
		.danger     (danger),
		.safe       (safe),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr)
	);

	// Freed-chunk stack
	fcpa_stack_mem #(
		.DEPTH(MAX_CHUNKS),
		.AW(AW),
		.DW(fcpa_pkg::IDX_W)
	) u_stack (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re   (mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	// Status and result register
	fcpa_status #(
		.MAX_CHUNKS(MAX_CHUNKS),
		.CW(CW)
	) u_status (
		.clk          (clk),
		.arst_n       (arst_n),
		.valid_s1     (valid_s1),
		.info_s1      (info_s1),
		.rd_data      (mem_rdata),
		.total        (total),
		.free         (free),
		.danger       (danger),
		.safe         (safe),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.ok           (ok),
		.granted_index(granted_index),
		.free_count   (free_count),
		.danger_excess(danger_excess),
		.over_safeline(over_safeline)
	);

endmodule

@@ rtl/fcpa_stack_mem.sv @@
// Freed-chunk stack storage: one write port, one read port, registered read.
// Depends on nothing; parameters come from the top level.
module fcpa_stack_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 10
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem_q [DEPTH];
	logic [DW-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, registered; data holds until the next read
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/fcpa_ctrl.sv @@
// Command decode, pool counters, config registers and the decode stage.
// Depends on fcpa_pkg and the assertion macro header.
`include "fixed_chunk_pool_allocator_unit_macros.svh"

module fcpa_ctrl #(
	parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF,
	parameter int CW         = $clog2(MAX_CHUNKS + 1),
	parameter int AW         = $clog2(MAX_CHUNKS)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// command channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [fcpa_pkg::CMD_W-1:0]    command,
	input  logic [fcpa_pkg::IDX_W-1:0]    chunk_index,
	// config port
	input  logic                          cfg_we,
	input  logic [fcpa_pkg::REG_W-1:0]    cfg_index,
	input  logic [fcpa_pkg::CFG_W-1:0]    cfg_data,
	// result stage
	input  logic                          out_free,
	output logic                          valid_s1,
	output fcpa_pkg::s1_info_t            info_s1,
	output logic [CW-1:0]                 total,
	output logic [CW-1:0]                 free,
	output logic [fcpa_pkg::CFG_W-1:0]    danger,
	output logic [fcpa_pkg::CFG_W-1:0]    safe,
	// stack memory
	output logic                          mem_we,
	output logic [AW-1:0]                 mem_waddr,
	output logic [fcpa_pkg::IDX_W-1:0]    mem_wdata,
	output logic                          mem_re,
	output logic [AW-1:0]                 mem_raddr
);

	localparam int LW = (CW > fcpa_pkg::CFG_W) ? CW : fcpa_pkg::CFG_W;
	localparam logic [CW-1:0] MAX_C = CW'(MAX_CHUNKS);
	localparam logic [CW-1:0] TOTAL_RST_C =
		CW'((fcpa_pkg::TOTAL_RST > MAX_CHUNKS) ? MAX_CHUNKS : fcpa_pkg::TOTAL_RST);

	logic [CW-1:0] total_q, free_q, run_q, depth_q;
	logic [fcpa_pkg::CFG_W-1:0] danger_q, safe_q;
	logic valid_s1_q;
	fcpa_pkg::s1_info_t info_s1_q;

	logic accept;
	logic do_pop, do_run, do_push, ok_c;
	logic [CW-1:0] depth_m1;
	logic [CW-1:0] total_wr;

	// Hold new commands only while the decode stage cannot drain
	assign in_stall = valid_s1_q & ~out_free;
	assign accept   = in_valid & ~in_stall;

	// Command decision from current counters
	always_comb begin
		do_pop  = 1'b0;
		do_run  = 1'b0;
		do_push = 1'b0;
		ok_c    = 1'b0;
		case (fcpa_pkg::cmd_t'(command))
			fcpa_pkg::CMD_ALLOC: begin
				if (free_q != '0) begin
					if (depth_q != '0) begin
						do_pop = 1'b1;
						ok_c   = 1'b1;
					end else if (run_q < total_q) begin
						do_run = 1'b1;
						ok_c   = 1'b1;
					end
				end
			end
			fcpa_pkg::CMD_FREE: begin
				if (free_q < total_q && LW'(chunk_index) < LW'(total_q) &&
				    depth_q < MAX_C) begin
					do_push = 1'b1;
					ok_c    = 1'b1;
				end
			end
			fcpa_pkg::CMD_QUERY: begin
				ok_c = 1'b1;
			end
			default: begin
				ok_c = 1'b0;
			end
		endcase
	end

	// Stack memory access: push writes the top, pop reads below it
	assign depth_m1  = depth_q - CW'(1);
	assign mem_we    = accept & do_push;
	assign mem_waddr = depth_q[AW-1:0];
	assign mem_wdata = chunk_index;
	assign mem_re    = accept & do_pop;
	assign mem_raddr = depth_m1[AW-1:0];

	// Saturate pool size to the storage depth
	assign total_wr = (LW'(cfg_data) > LW'(MAX_CHUNKS)) ? MAX_C : CW'(cfg_data);

	// Counters, config registers and stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q    <= TOTAL_RST_C;
			danger_q   <= fcpa_pkg::DANGER_RST;
			safe_q     <= fcpa_pkg::SAFE_RST;
			free_q     <= TOTAL_RST_C;
			run_q      <= '0;
			depth_q    <= '0;
			valid_s1_q <= 1'b0;
		end else begin
			if (accept) begin
				valid_s1_q <= 1'b1;
			end else if (out_free) begin
				valid_s1_q <= 1'b0;
			end
			if (accept) begin
				if (do_pop) begin
					depth_q <= depth_m1;
					free_q  <= free_q - CW'(1);
				end
				if (do_run) begin
					run_q  <= run_q + CW'(1);
					free_q <= free_q - CW'(1);
				end
				if (do_push) begin
					depth_q <= depth_q + CW'(1);
					free_q  <= free_q + CW'(1);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					fcpa_pkg::REG_TOTAL: begin
						total_q <= total_wr;
						free_q  <= total_wr;
						run_q   <= '0;
						depth_q <= '0;
					end
					fcpa_pkg::REG_DANGER: danger_q <= cfg_data;
					fcpa_pkg::REG_SAFE:   safe_q   <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Decode stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1_q.ok      <= ok_c;
			info_s1_q.pop     <= do_pop;
			info_s1_q.run_idx <= do_run ? fcpa_pkg::IDX_W'(run_q) : '0;
		end
	end

	assign valid_s1 = valid_s1_q;
	assign info_s1  = info_s1_q;
	assign total    = total_q;
	assign free     = free_q;
	assign danger   = danger_q;
	assign safe     = safe_q;

	// Every chunk is either free, granted from the run, or on the stack
	`FCPA_ASSERT_INV(a_pool_balance, clk, arst_n, (CW+1)'(free_q) + (CW+1)'(run_q) == (CW+1)'(total_q) + (CW+1)'(depth_q))
	`FCPA_ASSERT_INV(a_free_le_total, clk, arst_n, free_q <= total_q)
	`FCPA_ASSERT_NEXT(a_s1_holds, clk, arst_n, valid_s1_q && !out_free, valid_s1_q)

endmodule

@@ rtl/fcpa_status.sv @@
// Status math (used, safeline, danger excess) and the result register.
// Depends on fcpa_pkg and the assertion macro header.
`include "fixed_chunk_pool_allocator_unit_macros.svh"

module fcpa_status #(
	parameter int MAX_CHUNKS = fcpa_pkg::MAX_CHUNKS_DEF,
	parameter int CW         = $clog2(MAX_CHUNKS + 1)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid_s1,
	input  fcpa_pkg::s1_info_t            info_s1,
	input  logic [fcpa_pkg::IDX_W-1:0]    rd_data,
	input  logic [CW-1:0]                 total,
	input  logic [CW-1:0]                 free,
	input  logic [fcpa_pkg::CFG_W-1:0]    danger,
	input  logic [fcpa_pkg::CFG_W-1:0]    safe,
	output logic                          out_free,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          ok,
	output logic [fcpa_pkg::IDX_W-1:0]    granted_index,
	output logic [fcpa_pkg::CFG_W-1:0]    free_count,
	output logic [fcpa_pkg::CFG_W-1:0]    danger_excess,
	output logic                          over_safeline
);

	localparam int LW = (CW > fcpa_pkg::CFG_W) ? CW : fcpa_pkg::CFG_W;

	logic [LW-1:0] used_c, excess_c;
	logic over_c;
	logic out_valid_q, ok_q, over_q;
	logic [fcpa_pkg::IDX_W-1:0] granted_q;
	logic [fcpa_pkg::CFG_W-1:0] free_cnt_q, excess_q;

	// Counters already hold the post-command state
	assign used_c   = (total >= free) ? LW'(total) - LW'(free) : '0;
	assign over_c   = used_c > LW'(safe);
	assign excess_c = (used_c > LW'(danger) && over_c) ? used_c - LW'(safe) : '0;

	assign out_free = ~out_valid_q | ~out_stall;

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload; popped index comes from the stack read
	always_ff @(posedge clk) begin
		if (out_free && valid_s1) begin
			ok_q       <= info_s1.ok;
			granted_q  <= info_s1.pop ? rd_data : info_s1.run_idx;
			free_cnt_q <= fcpa_pkg::CFG_W'(free);
			excess_q   <= fcpa_pkg::CFG_W'(excess_c);
			over_q     <= over_c;
		end
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign granted_index = granted_q;
	assign free_count    = free_cnt_q;
	assign danger_excess = excess_q;
	assign over_safeline = over_q;

	// A failed command never reports a granted chunk
	`FCPA_ASSERT_INV(a_fail_no_grant, clk, arst_n, !out_valid_q || ok_q || granted_q == '0)
	// Danger excess is only reported above the safeline
	`FCPA_ASSERT_INV(a_excess_over, clk, arst_n, !out_valid_q || excess_q == '0 || over_q)

endmodule

@@ tb/fcpa_reply_checker.sv @@
`timescale 1ns / 1ps
// Reply checker for the chunk pool allocator: keeps its own copy of the pool,
// predicts one reply per accepted command beat and compares it with the DUT.
// Depends on fcpa_pkg for widths, command codes and register indexes.
module fcpa_reply_checker
	import fcpa_pkg::*;
#(
	parameter int MAX_CHUNKS = MAX_CHUNKS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_stall,
	input  logic [CMD_W-1:0] command,
	input  logic [IDX_W-1:0] chunk_index,
	input  logic             cfg_we,
	input  logic [REG_W-1:0] cfg_index,
	input  logic [CFG_W-1:0] cfg_data,
	input  logic             out_valid,
	input  logic             out_stall,
	input  logic             ok,
	input  logic [IDX_W-1:0] granted_index,
	input  logic [CFG_W-1:0] free_count,
	input  logic [CFG_W-1:0] danger_excess,
	input  logic             over_safeline,
	output int               fault_count,
	output int               replies_due,
	output int               replies_checked,
	output int               replies_refused
);

	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] grant;
		logic [CFG_W-1:0] free_cnt;
		logic [CFG_W-1:0] excess;
		logic             over;
	} pool_reply_t;

	// shadow pool: limits, LIFO of freed chunks, bump pointer, free count
	logic [CFG_W-1:0] pool_total, danger_lim, safe_lim;
	logic [IDX_W-1:0] freed_lifo [MAX_CHUNKS];
	logic [CFG_W-1:0] lifo_depth, bump_ptr, free_left;

	pool_reply_t owed_replies [$];

	function automatic logic [CFG_W-1:0] clamp_total(input logic [CFG_W-1:0] v);
		return (v > MAX_CHUNKS) ? CFG_W'(MAX_CHUNKS) : v;
	endfunction

	function automatic void restart_pool();
		lifo_depth = '0;
		bump_ptr   = '0;
		free_left  = pool_total;
	endfunction

	function automatic void apply_register(input logic [REG_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		if (idx == REG_TOTAL) begin
			pool_total = clamp_total(data);
			restart_pool();
		end else if (idx == REG_DANGER) begin
			danger_lim = data;
		end else if (idx == REG_SAFE) begin
			safe_lim = data;
		end
	endfunction

	// grant or take back one chunk and build the status reply
	function automatic pool_reply_t apply_command(input logic [CMD_W-1:0] cmd,
			input logic [IDX_W-1:0] idx);
		pool_reply_t r;
		logic [CFG_W-1:0] used;
		r = '0;
		if (cmd == CMD_ALLOC) begin
			if (free_left != 0) begin
				if (lifo_depth != 0) begin
					lifo_depth = lifo_depth - 1'b1;
					r.grant    = freed_lifo[lifo_depth[IDX_W-1:0]];
					free_left  = free_left - 1'b1;
					r.ok       = 1'b1;
				end else if (bump_ptr < pool_total) begin
					r.grant   = bump_ptr[IDX_W-1:0];
					bump_ptr  = bump_ptr + 1'b1;
					free_left = free_left - 1'b1;
					r.ok      = 1'b1;
				end
			end
		end else if (cmd == CMD_FREE) begin
			if (free_left < pool_total && {1'b0, idx} < pool_total &&
					lifo_depth < MAX_CHUNKS) begin
				freed_lifo[lifo_depth[IDX_W-1:0]] = idx;
				lifo_depth = lifo_depth + 1'b1;
				free_left  = free_left + 1'b1;
				r.ok       = 1'b1;
			end
		end else if (cmd == CMD_QUERY) begin
			r.ok = 1'b1;
		end
		// unknown command: status only, ok stays low
		used       = (pool_total >= free_left) ? pool_total - free_left : '0;
		r.free_cnt = free_left;
		r.over     = (used > safe_lim);
		if (used > danger_lim && used > safe_lim)
			r.excess = used - safe_lim;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_reply_t seen, want;
		if (!arst_n) begin
			pool_total = clamp_total(CFG_W'(TOTAL_RST));
			danger_lim = DANGER_RST;
			safe_lim   = SAFE_RST;
			restart_pool();
			owed_replies.delete();
			fault_count     = 0;
			replies_checked = 0;
			replies_refused = 0;
			replies_due <= 0;
		end else begin
			// result side first; a reply never leaves on its own command's edge
			if (out_valid && !out_stall) begin
				seen = {ok, granted_index, free_count, danger_excess, over_safeline};
				if (owed_replies.size() == 0) begin
					if (fault_count < 10)
						$display("%0t: reply with none owed: ok=%0d grant=%0d free=%0d excess=%0d over=%0d",
							$realtime, seen.ok, seen.grant, seen.free_cnt, seen.excess, seen.over);
					fault_count++;
				end else begin
					want = owed_replies.pop_front();
					replies_checked++;
					if (!want.ok)
						replies_refused++;
					if (seen.ok !== want.ok || seen.grant !== want.grant ||
							seen.free_cnt !== want.free_cnt || seen.excess !== want.excess ||
							seen.over !== want.over) begin
						if (fault_count < 10) begin
							$display("%0t: reply mismatch", $realtime);
							$display("  expected ok=%0d grant=%0d free=%0d excess=%0d over=%0d",
								want.ok, want.grant, want.free_cnt, want.excess, want.over);
							$display("  actual   ok=%0d grant=%0d free=%0d excess=%0d over=%0d",
								seen.ok, seen.grant, seen.free_cnt, seen.excess, seen.over);
						end
						fault_count++;
					end
				end
			end
			if (in_valid && !in_stall)
				owed_replies.push_back(apply_command(command, chunk_index));
			if (cfg_we)
				apply_register(cfg_index, cfg_data);
			replies_due <= owed_replies.size();
		end
	end

endmodule

@@ tb/fixed_chunk_pool_allocator_unit_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the chunk pool allocator: clock, reset, command and
// register stimulus, result-side stall pattern and the final verdict.
// Depends on fcpa_pkg, the DUT and fcpa_reply_checker.
module fixed_chunk_pool_allocator_unit_tb;
	import fcpa_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNKNOWN = 2'd3;
	localparam logic [REG_W-1:0] REG_SPARE   = 2'd3;
	localparam int CYCLE_LIMIT = 500000;

	typedef enum logic [1:0] {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_RUNS} rx_mode_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [CMD_W-1:0] command = CMD_QUERY;
	logic [IDX_W-1:0] chunk_index = '0;
	logic             cfg_we = 1'b0;
	logic [REG_W-1:0] cfg_index = REG_TOTAL;
	logic [CFG_W-1:0] cfg_data = '0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic             ok;
	logic [IDX_W-1:0] granted_index;
	logic [CFG_W-1:0] free_count;
	logic [CFG_W-1:0] danger_excess;
	logic             over_safeline;

	int fault_count, replies_due, replies_checked, replies_refused;
	int cycle_cnt = 0;
	int burst_left = 0;
	int beats_sent = 0;
	int settings_used = 1;

	rx_mode_t rx_mode = RX_OPEN;
	int rx_mode_left = 0;
	int rx_run_left = 0;

	fixed_chunk_pool_allocator_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.chunk_index   (chunk_index),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.granted_index (granted_index),
		.free_count    (free_count),
		.danger_excess (danger_excess),
		.over_safeline (over_safeline)
	);

	fcpa_reply_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.command         (command),
		.chunk_index     (chunk_index),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.ok              (ok),
		.granted_index   (granted_index),
		.free_count      (free_count),
		.danger_excess   (danger_excess),
		.over_safeline   (over_safeline),
		.fault_count     (fault_count),
		.replies_due     (replies_due),
		.replies_checked (replies_checked),
		.replies_refused (replies_refused)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies still owed", cycle_cnt, replies_due);
			$display("tb: failure");
			$finish;
		end
	end

	// result-side stall: open, light, heavy or long runs, switching now and then
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode      <= rx_mode_t'($urandom_range(0, 3));
				rx_mode_left <= $urandom_range(20, 200);
			end else begin
				rx_mode_left <= rx_mode_left - 1;
			end
			case (rx_mode)
				RX_OPEN: begin
					out_stall <= 1'b0;
				end
				RX_LIGHT: begin
					out_stall <= ($urandom_range(0, 3) == 0);
				end
				RX_HEAVY: begin
					out_stall <= ($urandom_range(0, 9) < 7);
				end
				default: begin
					if (rx_run_left == 0) begin
						out_stall   <= !out_stall;
						rx_run_left <= $urandom_range(1, 12);
					end else begin
						rx_run_left <= rx_run_left - 1;
					end
				end
			endcase
		end
	end

	// one register write, entered and left at a clock edge
	task automatic write_reg(input logic [REG_W-1:0] index, input logic [CFG_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= index;
		cfg_data  <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic program_pool(input int total, input int danger, input int safe);
		write_reg(REG_TOTAL, CFG_W'(total));
		write_reg(REG_DANGER, CFG_W'(danger));
		write_reg(REG_SAFE, CFG_W'(safe));
		settings_used++;
	endtask

	// stop sending and wait until every owed reply has come back
	task automatic quiesce();
		in_valid <= 1'b0;
		burst_left = 0;
		do @(posedge clk); while (replies_due != 0);
		repeat (4) @(posedge clk);
	endtask

	// one command beat; bursts of random length with random gaps between them
	task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx);
		int gap;
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 20) : $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
				: $urandom_range(1, 12);
		end
		in_valid    <= 1'b1;
		command     <= cmd;
		chunk_index <= idx;
		do @(posedge clk); while (in_stall);
		burst_left--;
		beats_sent++;
	endtask

	// random traffic under one setting; in pools under 512 chunks, alloc-heavy
	// and free-heavy stretches alternate so small pools swing between empty and full
	task automatic run_phase(input int total, input int danger, input int safe, input int count);
		int span, roll, alloc_pct, free_pct;
		logic [CMD_W-1:0] cmd;
		logic [IDX_W-1:0] idx;
		quiesce();
		program_pool(total, danger, safe);
		span = (total > MAX_CHUNKS_DEF) ? MAX_CHUNKS_DEF : total;
		for (int i = 0; i < count; i++) begin
			if (count >= 400 && i == count / 2)
				quiesce();
			if (span >= 512 || (i / 40) % 2 == 0) begin
				alloc_pct = 80;
				free_pct  = 15;
			end else begin
				alloc_pct = 20;
				free_pct  = 75;
			end
			roll = $urandom_range(0, 99);
			idx  = $urandom_range(0, 1023);
			if (roll < alloc_pct) begin
				cmd = CMD_ALLOC;
			end else if (roll < alloc_pct + free_pct) begin
				cmd = CMD_FREE;
				if (span > 0 && $urandom_range(0, 99) < 85)
					idx = $urandom_range(0, span - 1);
			end else if (roll < 98) begin
				cmd = CMD_QUERY;
			end else begin
				cmd = CMD_UNKNOWN;
			end
			send_beat(cmd, idx);
		end
	endtask

	initial begin
		int total;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pool: run grants, reuse of a freed chunk, double free, unknown command
		send_beat(CMD_QUERY, 10'h3FF);
		send_beat(CMD_ALLOC, 10'h000);
		send_beat(CMD_ALLOC, 10'h155);
		send_beat(CMD_FREE, 10'h3FF);
		send_beat(CMD_ALLOC, 10'h2AA);
		send_beat(CMD_FREE, 10'h000);
		send_beat(CMD_FREE, 10'h000);
		send_beat(CMD_ALLOC, 10'h000);
		send_beat(CMD_ALLOC, 10'h000);
		send_beat(CMD_UNKNOWN, 10'h3FF);

		// three chunks: free into a full pool, exhaustion, out-of-range frees
		quiesce();
		program_pool(3, 1, 0);
		send_beat(CMD_FREE, 10'd2);
		repeat (4) send_beat(CMD_ALLOC, 10'd0);
		send_beat(CMD_FREE, 10'd3);
		send_beat(CMD_FREE, 10'h3FF);
		send_beat(CMD_FREE, 10'd2);

		// oversized total saturates; safe limit above used keeps excess at zero
		quiesce();
		program_pool(2047, 0, 2047);
		send_beat(CMD_ALLOC, 10'd0);
		send_beat(CMD_QUERY, 10'd0);

		// zero-chunk pool is always empty and always full
		quiesce();
		program_pool(0, 0, 0);
		send_beat(CMD_ALLOC, 10'd0);
		send_beat(CMD_FREE, 10'd0);
		send_beat(CMD_QUERY, 10'd0);

		// write to the unused register index changes nothing
		quiesce();
		write_reg(REG_SPARE, 11'h7FF);
		send_beat(CMD_QUERY, 10'd0);

		// random traffic over a range of settings
		run_phase(16, 12, 10, 300);
		run_phase(1, 0, 0, 150);
		run_phase(1024, 200, 150, 500);
		repeat (3) begin
			total = $urandom_range(2, 64);
			run_phase(total, $urandom_range(0, total + 2), $urandom_range(0, total + 2), 150);
		end
		run_phase(2047, 2047, 0, 200);
		run_phase(40, 0, 2047, 250);

		quiesce();
		repeat (8) @(posedge clk);

		$display("summary: %0d commands under %0d pool settings, %0d replies checked",
			beats_sent, settings_used, replies_checked);
		$display("summary: %0d refused commands, %0d faults", replies_refused, fault_count);
		if (fault_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
